// ----- rtl/vfbc_pkg.sv -----
// Package for the view frustum box cull unit: widths, register codes,
// word layouts and pipeline enable struct. Depends on nothing.
`default_nettype none

package vfbc_pkg;

	// Field widths
	localparam int COORD_BITS = 32;
	localparam int COEF_BITS  = 16;
	localparam int COEF_FRAC  = COEF_BITS - 2;
	localparam int TAG_W      = 16;
	localparam int TAN_W      = 16;
	localparam int TAN_FRAC   = 12;
	localparam int PLANE_W    = 31;
	localparam int OFF_W      = 32;
	localparam int ROW_W      = 3 * COEF_BITS;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 3;

	// Datapath widths
	localparam int PT_W   = COORD_BITS + 1;          // center plus offset
	localparam int PROD_W = PT_W + COEF_BITS;        // coefficient product
	localparam int VIEW_W = PROD_W + 2;              // three products plus offset
	localparam int ZQ_W   = PLANE_W + COEF_FRAC;     // near/far aligned to view scale
	localparam int LO_W   = (ZQ_W + 1) / 2;          // low half of view z
	localparam int HI_W   = ZQ_W - LO_W;             // high half of view z

	// Horizontal tangent: floor(tan * 1399 / 662)
	localparam int HFOV_NUM  = 1399;
	localparam int HFOV_DEN  = 662;
	localparam int NUM_W     = 11;
	localparam int DEN_W     = 10;
	localparam int HX_W      = TAN_W + NUM_W;
	localparam int TANH_W    = TAN_W + 2;
	localparam int RECIP_SH  = HX_W + DEN_W - 1;
	localparam int RECIP_W   = RECIP_SH - DEN_W + 1;
	localparam longint unsigned RECIP_M = (64'd1 << RECIP_SH) / HFOV_DEN;
	localparam int CMP_W = (VIEW_W > TANH_W + ZQ_W) ? VIEW_W : TANH_W + ZQ_W;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_VIEW_ROW_X     = 3'd0,
		REG_VIEW_ROW_Y     = 3'd1,
		REG_VIEW_ROW_Z     = 3'd2,
		REG_VIEW_OFFSET_XY = 3'd3,
		REG_VIEW_OFFSET_Z  = 3'd4,
		REG_NEAR_PLANE     = 3'd5,
		REG_FAR_PLANE      = 3'd6,
		REG_TAN_HALF_FOV_V = 3'd7
	} cfg_reg_t;

	// Tested point codes
	typedef enum logic [1:0] {
		POINT_NONE   = 2'd0,
		POINT_CENTER = 2'd1,
		POINT_MIN    = 2'd2,
		POINT_MAX    = 2'd3
	} point_t;

	// Input word, first field in the lowest bits
	typedef struct packed {
		logic signed [COORD_BITS-1:0] max_off_z;
		logic signed [COORD_BITS-1:0] max_off_y;
		logic signed [COORD_BITS-1:0] max_off_x;
		logic signed [COORD_BITS-1:0] min_off_z;
		logic signed [COORD_BITS-1:0] min_off_y;
		logic signed [COORD_BITS-1:0] min_off_x;
		logic signed [COORD_BITS-1:0] center_z;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_x;
		logic [TAG_W-1:0]             obj_tag;
	} in_word_t;

	localparam int IN_W = $bits(in_word_t);

	// Result word, first field in the lowest bits, padded to bytes
	typedef struct packed {
		logic [4:0]       pad;
		point_t           inside_point;
		logic             culled;
		logic [TAG_W-1:0] out_tag;
	} out_word_t;

	localparam int OUT_W = $bits(out_word_t);

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

`default_nettype wire

// ----- rtl/vfbc_tanh.sv -----
// Derives the horizontal half-angle tangent from the vertical one.
// Depends on vfbc_pkg; a free-running three-register pipeline.
`default_nettype none

module vfbc_tanh (
	input  wire                            clk,
	input  wire [vfbc_pkg::TAN_W-1:0]      tan_v,
	output logic [vfbc_pkg::TANH_W-1:0]    tan_h
);

	localparam int P_W = vfbc_pkg::HX_W + vfbc_pkg::RECIP_W;

	logic [vfbc_pkg::RECIP_W-1:0] recip;
	logic [vfbc_pkg::HX_W-1:0]    x_q;
	logic [vfbc_pkg::HX_W-1:0]    xd_q;
	logic [P_W-1:0]               p_q;
	logic [vfbc_pkg::TANH_W-1:0]  q0;
	logic [vfbc_pkg::HX_W:0]      rem;
	logic [vfbc_pkg::TANH_W-1:0]  tanh_q;

	assign recip = vfbc_pkg::RECIP_W'(vfbc_pkg::RECIP_M);

	// Scale by the numerator, then multiply by the reciprocal of the denominator
	always_ff @(posedge clk) begin
		x_q  <= tan_v * vfbc_pkg::NUM_W'(vfbc_pkg::HFOV_NUM);
		p_q  <= x_q * recip;
		xd_q <= x_q;
	end

	// Estimate is low by at most one: fix it with one remainder compare
	always_comb begin
		q0  = vfbc_pkg::TANH_W'(p_q >> vfbc_pkg::RECIP_SH);
		rem = {1'b0, xd_q} - (vfbc_pkg::HX_W + 1)'(q0 * vfbc_pkg::DEN_W'(vfbc_pkg::HFOV_DEN));
	end

	always_ff @(posedge clk) begin
		if (rem >= (vfbc_pkg::HX_W + 1)'(vfbc_pkg::HFOV_DEN)) begin
			tanh_q <= q0 + vfbc_pkg::TANH_W'(1);
		end else begin
			tanh_q <= q0;
		end
	end

	assign tan_h = tanh_q;

endmodule

`default_nettype wire

// ----- rtl/vfbc_lane.sv -----
// One point-test lane: view transform, depth window and side tests.
// Depends on vfbc_pkg; stages s1..s5 load on the enables from the top level.
`default_nettype none

module vfbc_lane (
	input  wire                                   clk,
	input  wire vfbc_pkg::stage_en_t              en,
	input  wire signed [vfbc_pkg::PT_W-1:0]       px,
	input  wire signed [vfbc_pkg::PT_W-1:0]       py,
	input  wire signed [vfbc_pkg::PT_W-1:0]       pz,
	input  wire [vfbc_pkg::ROW_W-1:0]             row_x,
	input  wire [vfbc_pkg::ROW_W-1:0]             row_y,
	input  wire [vfbc_pkg::ROW_W-1:0]             row_z,
	input  wire signed [vfbc_pkg::OFF_W-1:0]      off_x,
	input  wire signed [vfbc_pkg::OFF_W-1:0]      off_y,
	input  wire signed [vfbc_pkg::OFF_W-1:0]      off_z,
	input  wire [vfbc_pkg::PLANE_W-1:0]           near_plane,
	input  wire [vfbc_pkg::PLANE_W-1:0]           far_plane,
	input  wire [vfbc_pkg::TAN_W-1:0]             tan_v,
	input  wire [vfbc_pkg::TANH_W-1:0]            tan_h,
	output logic                                  inside_s5
);

	localparam int VW  = vfbc_pkg::VIEW_W;
	localparam int CB  = vfbc_pkg::COEF_BITS;
	localparam int LO  = vfbc_pkg::LO_W;
	localparam int HI  = vfbc_pkg::HI_W;
	localparam int ZQ  = vfbc_pkg::ZQ_W;
	localparam int CW  = vfbc_pkg::CMP_W;

	logic [vfbc_pkg::ROW_W-1:0]          rows      [3];
	logic signed [CB-1:0]                coef      [3][3];
	logic signed [VW-1:0]                off_al    [3];
	logic signed [vfbc_pkg::PT_W-1:0]    pt_s1     [3];
	logic signed [vfbc_pkg::PROD_W-1:0]  prod_s2   [3][3];
	logic signed [VW-1:0]                view_s3   [3];
	logic                                zok_s4;
	logic [VW-1:0]                       mag_x_s4;
	logic [VW-1:0]                       mag_y_s4;
	logic [vfbc_pkg::TAN_W+LO-1:0]       ty_lo_s4;
	logic [vfbc_pkg::TAN_W+HI-1:0]       ty_hi_s4;
	logic [vfbc_pkg::TANH_W+LO-1:0]      tx_lo_s4;
	logic [vfbc_pkg::TANH_W+HI-1:0]      tx_hi_s4;
	logic signed [VW-1:0]                vz;
	logic [ZQ-1:0]                       near_q;
	logic [ZQ-1:0]                       far_q;
	logic                                zok;
	logic [CW-1:0]                       lim_y;
	logic [CW-1:0]                       lim_x;

	// Split the packed rows into signed coefficients, align offsets
	always_comb begin
		rows[0] = row_x;
		rows[1] = row_y;
		rows[2] = row_z;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				coef[r][k] = signed'(rows[r][k*CB +: CB]);
			end
		end
		off_al[0] = VW'(off_x) <<< vfbc_pkg::COEF_FRAC;
		off_al[1] = VW'(off_y) <<< vfbc_pkg::COEF_FRAC;
		off_al[2] = VW'(off_z) <<< vfbc_pkg::COEF_FRAC;
	end

	// s1: capture the point
	always_ff @(posedge clk) begin
		if (en.s1) begin
			pt_s1[0] <= px;
			pt_s1[1] <= py;
			pt_s1[2] <= pz;
		end
	end

	// s2: nine coefficient products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[r][k] <= coef[r][k] * pt_s1[k];
				end
			end
		end
	end

	// s3: row sums plus translation
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int r = 0; r < 3; r++) begin
				view_s3[r] <= VW'(prod_s2[r][0]) + VW'(prod_s2[r][1])
					+ VW'(prod_s2[r][2]) + off_al[r];
			end
		end
	end

	// s4: depth window, magnitudes, tangent partial products
	always_comb begin
		vz     = view_s3[2];
		near_q = {near_plane, {vfbc_pkg::COEF_FRAC{1'b0}}};
		far_q  = {far_plane, {vfbc_pkg::COEF_FRAC{1'b0}}};
		zok    = !vz[VW-1] && (vz != '0)
			&& ($unsigned(vz) >= VW'(near_q)) && ($unsigned(vz) <= VW'(far_q));
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			zok_s4   <= zok;
			mag_x_s4 <= view_s3[0][VW-1] ? $unsigned(-view_s3[0]) : $unsigned(view_s3[0]);
			mag_y_s4 <= view_s3[1][VW-1] ? $unsigned(-view_s3[1]) : $unsigned(view_s3[1]);
			ty_lo_s4 <= tan_v * vz[LO-1:0];
			ty_hi_s4 <= tan_v * vz[ZQ-1:LO];
			tx_lo_s4 <= tan_h * vz[LO-1:0];
			tx_hi_s4 <= tan_h * vz[ZQ-1:LO];
		end
	end

	// s5: rebuild the tangent limits and compare
	always_comb begin
		lim_y = ((CW'(ty_hi_s4) << LO) + CW'(ty_lo_s4)) >> vfbc_pkg::TAN_FRAC;
		lim_x = ((CW'(tx_hi_s4) << LO) + CW'(tx_lo_s4)) >> vfbc_pkg::TAN_FRAC;
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			inside_s5 <= zok_s4 && (CW'(mag_y_s4) <= lim_y) && (CW'(mag_x_s4) <= lim_x);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/vfbc_merge.sv -----
// Merges the three lane verdicts by priority into the result word register.
// Depends on vfbc_pkg; loads on the last stage enable.
`default_nettype none

module vfbc_merge (
	input  wire                                clk,
	input  wire vfbc_pkg::stage_en_t           en,
	input  wire [vfbc_pkg::TAG_W-1:0]          tag_s5,
	input  wire [2:0]                          inside_s5,
	output vfbc_pkg::out_word_t                out_word
);

	vfbc_pkg::point_t    which;
	vfbc_pkg::out_word_t out_q;

	// First inside point wins: center, then min corner, then max corner
	always_comb begin
		if (inside_s5[0]) begin
			which = vfbc_pkg::POINT_CENTER;
		end else if (inside_s5[1]) begin
			which = vfbc_pkg::POINT_MIN;
		end else if (inside_s5[2]) begin
			which = vfbc_pkg::POINT_MAX;
		end else begin
			which = vfbc_pkg::POINT_NONE;
		end
	end

	// Hold the result word until the receiver takes it
	always_ff @(posedge clk) begin
		if (en.s6) begin
			out_q.pad          <= '0;
			out_q.inside_point <= which;
			out_q.culled       <= (which == vfbc_pkg::POINT_NONE);
			out_q.out_tag      <= tag_s5;
		end
	end

	assign out_word = out_q;

endmodule

`default_nettype wire

// ----- rtl/view_frustum_box_cull_unit.sv -----
// View frustum box cull unit, top level: configuration registers, input
// unpack, corner sums, stage valid chain, three lanes and the merge stage.
// Depends on vfbc_pkg, vfbc_tanh, vfbc_lane and vfbc_merge.
//
// Usage: each word on the s_ channel describes one object (tag, center,
// min and max corner offsets). The center, min corner and max corner go
// through the configured affine view transform in three parallel lanes and
// are tested against the near/far window and the two tangent limits. One
// result word per object leaves on the m_ channel: tag, culled flag and the
// first point found inside.
// The input word is taken at s1; the result word is registered at s6.
// Throughput: one object per cycle while no stage is held; the pipeline
// has six register stages and every stage can load each cycle.
// Stalls: a full stage holds while its successor cannot move, so the
// unit keeps taking words into empty stages while a result waits; with all
// six stages full and m_tready low, s_tready drops.
// Configuration: write enable, index and data, taken on any edge with
// cfg_we high. A tangent write reaches tan_h via x_q, p_q and tanh_q.
// Reset clears all stage valids and loads the default view.
`default_nettype none

module view_frustum_box_cull_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// obj_tag, center_x/y/z, min_off_x/y/z, max_off_x/y/z (lowest first)
	input  wire [vfbc_pkg::IN_W-1:0]             s_tdata,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// out_tag, culled, inside_point, zero pad (lowest first)
	output logic [vfbc_pkg::OUT_W-1:0]           m_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	input  wire                                  cfg_we,
	input  wire [vfbc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire [vfbc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int PW = vfbc_pkg::PT_W;

	// Configuration registers
	logic [vfbc_pkg::ROW_W-1:0]          row_x_q;
	logic [vfbc_pkg::ROW_W-1:0]          row_y_q;
	logic [vfbc_pkg::ROW_W-1:0]          row_z_q;
	logic [2*vfbc_pkg::OFF_W-1:0]        off_xy_q;
	logic [vfbc_pkg::OFF_W-1:0]          off_z_q;
	logic [vfbc_pkg::PLANE_W-1:0]        near_q;
	logic [vfbc_pkg::PLANE_W-1:0]        far_q;
	logic [vfbc_pkg::TAN_W-1:0]          tan_q;
	logic [vfbc_pkg::TANH_W-1:0]         tan_h;

	vfbc_pkg::in_word_t                  in_w;
	vfbc_pkg::out_word_t                 out_w;
	vfbc_pkg::stage_en_t                 en;
	logic [5:1]                          valid_q;
	logic                                out_valid_q;
	logic [6:1]                          rdy;
	logic [vfbc_pkg::TAG_W-1:0]          tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [PW-1:0]                pt_x [3];
	logic signed [PW-1:0]                pt_y [3];
	logic signed [PW-1:0]                pt_z [3];
	logic [2:0]                          inside_s5;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= vfbc_pkg::ROW_W'(48'h0000_0000_4000);
			row_y_q  <= vfbc_pkg::ROW_W'(48'h0000_4000_0000);
			row_z_q  <= vfbc_pkg::ROW_W'(48'h4000_0000_0000);
			off_xy_q <= '0;
			off_z_q  <= '0;
			near_q   <= vfbc_pkg::PLANE_W'(31'h0001_0000);
			far_q    <= vfbc_pkg::PLANE_W'(31'h7FFF_FFFF);
			tan_q    <= vfbc_pkg::TAN_W'(16'h1000);
		end else if (cfg_we) begin
			unique case (vfbc_pkg::cfg_reg_t'(cfg_addr))
				vfbc_pkg::REG_VIEW_ROW_X:     row_x_q  <= cfg_wdata[vfbc_pkg::ROW_W-1:0];
				vfbc_pkg::REG_VIEW_ROW_Y:     row_y_q  <= cfg_wdata[vfbc_pkg::ROW_W-1:0];
				vfbc_pkg::REG_VIEW_ROW_Z:     row_z_q  <= cfg_wdata[vfbc_pkg::ROW_W-1:0];
				vfbc_pkg::REG_VIEW_OFFSET_XY: off_xy_q <= cfg_wdata[2*vfbc_pkg::OFF_W-1:0];
				vfbc_pkg::REG_VIEW_OFFSET_Z:  off_z_q  <= cfg_wdata[vfbc_pkg::OFF_W-1:0];
				vfbc_pkg::REG_NEAR_PLANE:     near_q   <= cfg_wdata[vfbc_pkg::PLANE_W-1:0];
				vfbc_pkg::REG_FAR_PLANE:      far_q    <= cfg_wdata[vfbc_pkg::PLANE_W-1:0];
				vfbc_pkg::REG_TAN_HALF_FOV_V: tan_q    <= cfg_wdata[vfbc_pkg::TAN_W-1:0];
			endcase
		end
	end

	vfbc_tanh u_tanh (
		.clk   (clk),
		.tan_v (tan_q),
		.tan_h (tan_h)
	);

	// Stage readiness: a stage loads when empty or when its successor moves
	always_comb begin
		rdy[6] = !out_valid_q || m_tready;
		for (int k = 5; k >= 1; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		en.s1 = rdy[1];
		en.s2 = rdy[2];
		en.s3 = rdy[3];
		en.s4 = rdy[4];
		en.s5 = rdy[5];
		en.s6 = rdy[6];
	end

	assign s_tready = rdy[1];

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[1]) valid_q[1] <= s_tvalid;
			for (int k = 2; k <= 5; k++) begin
				if (rdy[k]) valid_q[k] <= valid_q[k-1];
			end
			if (rdy[6]) out_valid_q <= valid_q[5];
		end
	end

	// Carry the tag alongside the lanes
	always_ff @(posedge clk) begin
		if (en.s1) tag_s1 <= in_w.obj_tag;
		if (en.s2) tag_s2 <= tag_s1;
		if (en.s3) tag_s3 <= tag_s2;
		if (en.s4) tag_s4 <= tag_s3;
		if (en.s5) tag_s5 <= tag_s4;
	end

	// Unpack the word and form the two corners
	always_comb begin
		in_w    = vfbc_pkg::in_word_t'(s_tdata);
		pt_x[0] = PW'(in_w.center_x);
		pt_y[0] = PW'(in_w.center_y);
		pt_z[0] = PW'(in_w.center_z);
		pt_x[1] = PW'(in_w.center_x) + PW'(in_w.min_off_x);
		pt_y[1] = PW'(in_w.center_y) + PW'(in_w.min_off_y);
		pt_z[1] = PW'(in_w.center_z) + PW'(in_w.min_off_z);
		pt_x[2] = PW'(in_w.center_x) + PW'(in_w.max_off_x);
		pt_y[2] = PW'(in_w.center_y) + PW'(in_w.max_off_y);
		pt_z[2] = PW'(in_w.center_z) + PW'(in_w.max_off_z);
	end

	// One lane per tested point
	for (genvar i = 0; i < 3; i++) begin : g_lane
		vfbc_lane u_lane (
			.clk        (clk),
			.en         (en),
			.px         (pt_x[i]),
			.py         (pt_y[i]),
			.pz         (pt_z[i]),
			.row_x      (row_x_q),
			.row_y      (row_y_q),
			.row_z      (row_z_q),
			.off_x      (off_xy_q[vfbc_pkg::OFF_W-1:0]),
			.off_y      (off_xy_q[2*vfbc_pkg::OFF_W-1:vfbc_pkg::OFF_W]),
			.off_z      (off_z_q),
			.near_plane (near_q),
			.far_plane  (far_q),
			.tan_v      (tan_q),
			.tan_h      (tan_h),
			.inside_s5  (inside_s5[i])
		);
	end

	vfbc_merge u_merge (
		.clk       (clk),
		.en        (en),
		.tag_s5    (tag_s5),
		.inside_s5 (inside_s5),
		.out_word  (out_w)
	);

	assign m_tdata  = out_w;
	assign m_tvalid = out_valid_q;

	// A result word flags culled exactly when it names no inside point
	a_culled_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_w.culled == (out_w.inside_point == vfbc_pkg::POINT_NONE)))
		else $error("culled flag disagrees with inside point code");

	// With the output register empty, every stage can move, so input is taken
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

	// A stalled result keeps its place and the stage behind it stays full
	a_stall_keeps_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && valid_q[5]) |=> (m_tvalid && valid_q[5]))
		else $error("pipeline lost a word during an output stall");

endmodule

`default_nettype wire
